[design/rme_pkg.sv]
// Shared constants and a helper function for the RAM machine executor.
package rme_pkg;

  localparam int RegCount  = 64;
  localparam int ProgDepth = 1024;
  localparam int RegAw     = $clog2(RegCount);
  localparam int PcW       = 10;

  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_STORE = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_MULT  = 4'd4;
  localparam logic [3:0] OP_DIV   = 4'd5;
  localparam logic [3:0] OP_READ  = 4'd6;
  localparam logic [3:0] OP_WRITE = 4'd7;
  localparam logic [3:0] OP_JUMP  = 4'd8;
  localparam logic [3:0] OP_JGTZ  = 4'd9;
  localparam logic [3:0] OP_JZERO = 4'd10;
  localparam logic [3:0] OP_HALT  = 4'd11;

  localparam logic [1:0] MODE_IMM   = 2'd0;
  localparam logic [1:0] MODE_DIR   = 2'd1;
  localparam logic [1:0] MODE_IND   = 2'd2;
  localparam logic [1:0] MODE_LABEL = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_MODE = 3'd1;
  localparam logic [2:0] ST_IMM_ST   = 3'd2;
  localparam logic [2:0] ST_IMM_RD   = 3'd3;
  localparam logic [2:0] ST_WR_ACC   = 3'd4;
  localparam logic [2:0] ST_DIV_ZERO = 3'd5;
  localparam logic [2:0] ST_HALTED   = 3'd6;
  localparam logic [2:0] ST_BAD_IDX  = 3'd7;

  // index in range of the register file
  function automatic logic good_reg(input logic signed [31:0] i);
    return (i >= 0) && (i < RegCount);
  endfunction

endpackage

[design/rme_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
module rme_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import rme_pkg::*;

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  // restoring division on magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= dividend[31] ? 32'(-dividend) : dividend;
        dvs  <= divisor[31] ? 32'(-divisor) : divisor;
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 32'(-quo) : quo;
endmodule

[design/rme_regfile.sv]
// Register file memory with one synchronous read port and one write port.
module rme_regfile (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rme_pkg::RegAw-1:0] rd_addr,
  output logic [31:0]               rd_data,
  input  logic                      wr_en,
  input  logic [rme_pkg::RegAw-1:0] wr_addr,
  input  logic [31:0]               wr_data,
  output logic                      clearing
);
  import rme_pkg::*;

  logic [31:0]     mem [RegCount];
  logic [RegAw:0]  clr_cnt;

  assign clearing = !clr_cnt[RegAw];

  // clearing sweep after reset, then normal writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[RegAw-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[design/ram_machine_executor.sv]
// Top level: accumulator RAM machine executor.
// Path to a result: jumps and early errors end at decode; immediate operands go straight
// to execute, direct ones read a register first, indirect ones read a pointer and then
// the value, and DIV then waits on the iterative divider. One instruction at a time:
// the next is accepted in the cycle after the result is taken. Reset clears pc and
// accumulator at once and sweeps the register file (input stalled meanwhile).
module ram_machine_executor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic [1:0]  addr_mode,
  input  logic signed [31:0] operand_value,
  input  logic signed [31:0] tape_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [9:0]  next_pc,
  output logic        tape_out_valid,
  output logic signed [31:0] tape_out,
  output logic signed [31:0] acc_now
);
  import rme_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PTR, S_PTR_WAIT, S_VAL, S_EXEC, S_DIV, S_DONE
  } state_t;

  state_t      state;
  logic [3:0]  act;
  logic [1:0]  mode;
  logic [31:0] opnd;
  logic [31:0] tape;
  logic [31:0] idx;
  logic [31:0] acc;
  logic [PcW-1:0] pc;
  logic [RegAw-1:0] rd_addr;
  logic [31:0] rd_data;
  logic        wr_en;
  logic [RegAw-1:0] wr_addr;
  logic [31:0] wr_data;
  logic        clearing;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] dvs_val;
  logic [PcW-1:0] inc;
  logic [31:0] prod;

  rme_regfile u_rf (
    .clk, .rst, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data, .clearing
  );

  rme_div u_div (
    .clk, .rst, .start(div_start), .dividend(acc), .divisor(dvs_val),
    .done(div_done), .quotient(div_q)
  );

  assign inc      = (32'(pc) + 32'd1 >= ProgDepth) ? '0 : PcW'(pc + 1'b1);
  assign in_stall = (state != S_IDLE) || clearing;
  assign next_pc  = pc;
  assign acc_now  = acc;
  assign prod     = acc * rd_data;

  // read address follows the current phase
  always_comb begin
    rd_addr = RegAw'(opnd);
    if (state == S_PTR_WAIT) rd_addr = RegAw'(rd_data);
    else if (state == S_VAL) rd_addr = RegAw'(idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pc        <= '0;
      acc       <= '0;
      wr_en     <= 1'b0;
      div_start <= 1'b0;
    end else begin
      wr_en     <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !clearing) begin
            act  <= action;
            mode <= addr_mode;
            opnd <= operand_value;
            tape <= tape_in;
            tape_out_valid <= 1'b0;
            tape_out <= '0;
            state <= S_PTR;
          end
        end
        // decode and checks not needing register data
        S_PTR: begin
          if (act > OP_HALT) begin
            status <= ST_BAD_MODE;
            state  <= S_DONE;
          end else if (act == OP_HALT) begin
            status <= ST_HALTED;
            state  <= S_DONE;
          end else if (act >= OP_JUMP) begin
            state <= S_DONE;
            if (mode != MODE_LABEL) status <= ST_BAD_MODE;
            else if ($signed(opnd) < 0 || $signed(opnd) >= ProgDepth)
              status <= ST_BAD_IDX;
            else begin
              status <= ST_OK;
              if (act == OP_JUMP || (act == OP_JGTZ && $signed(acc) > 0) ||
                  (act == OP_JZERO && acc == 0))
                pc <= PcW'(opnd);
              else pc <= inc;
            end
          end else if (mode == MODE_LABEL) begin
            status <= ST_BAD_MODE;
            state  <= S_DONE;
          end else if (mode == MODE_IMM && act == OP_STORE) begin
            status <= ST_IMM_ST;
            state  <= S_DONE;
          end else if (mode == MODE_IMM && act == OP_READ) begin
            status <= ST_IMM_RD;
            state  <= S_DONE;
          end else if (mode == MODE_DIR && act == OP_WRITE && opnd == 0) begin
            status <= ST_WR_ACC;
            state  <= S_DONE;
          end else if (mode != MODE_IMM && !good_reg(opnd)) begin
            status <= ST_BAD_IDX;
            state  <= S_DONE;
          end else begin
            status <= ST_OK;
            if (mode == MODE_IMM) state <= S_EXEC;
            else if (mode == MODE_IND) state <= S_PTR_WAIT;
            else begin
              idx   <= opnd;
              state <= S_VAL;
            end
          end
        end
        // pointer data now on rd_data; reads value at pointer
        S_PTR_WAIT: begin
          idx <= rd_data;
          if (!good_reg(rd_data)) begin
            status <= ST_BAD_IDX;
            state  <= S_DONE;
          end else state <= S_VAL;
        end
        S_VAL: state <= S_EXEC;
        // operand value on rd_data (or immediate)
        S_EXEC: begin
          if (act != OP_DIV) begin
            state <= S_DONE;
            pc    <= inc;
          end
          case (act)
            OP_LOAD: acc <= (mode == MODE_IMM) ? opnd : rd_data;
            OP_STORE: begin
              wr_en <= 1'b1; wr_addr <= RegAw'(idx); wr_data <= acc;
            end
            OP_ADD: acc <= acc + ((mode == MODE_IMM) ? opnd : rd_data);
            OP_SUB: acc <= acc - ((mode == MODE_IMM) ? opnd : rd_data);
            OP_MULT: acc <= (mode == MODE_IMM) ? acc * opnd : prod;
            OP_DIV: begin
              if (((mode == MODE_IMM) ? opnd : rd_data) == 0) begin
                status <= ST_DIV_ZERO;
                state  <= S_DONE;
              end else begin
                div_start <= 1'b1;
                dvs_val   <= (mode == MODE_IMM) ? opnd : rd_data;
                state     <= S_DIV;
              end
            end
            OP_READ: begin
              wr_en <= 1'b1; wr_addr <= RegAw'(idx); wr_data <= tape;
            end
            default: begin
              tape_out_valid <= 1'b1;
              tape_out <= (mode == MODE_IMM) ? opnd : rd_data;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            acc   <= div_q;
            pc    <= inc;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // accumulator is register 0; keep memory copy in step
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (status == ST_OK && act != OP_STORE && act != OP_READ &&
                act < OP_JUMP) begin
              wr_en <= 1'b1; wr_addr <= '0; wr_data <= acc;
            end
            if (status == ST_OK && (act == OP_STORE || act == OP_READ) &&
                wr_addr == '0)
              acc <= wr_data;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[design/rme_checker.sv]
// Port-level checker for the RAM machine executor, bound to the top level.
module rme_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [9:0]  next_pc,
  input logic        tape_out_valid,
  input logic [31:0] tape_out
);
  import rme_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(next_pc))
    else $error("result changed while stalled");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !tape_out_valid && tape_out == 0)
    else $error("tape output on error");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_pc_err: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> $stable(next_pc))
    else $error("pc moved at accept");
endmodule

bind ram_machine_executor rme_checker u_rme_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status,
  .next_pc, .tape_out_valid, .tape_out
);
